// ===== src/tdpt_pkg.sv =====
// shared types and constants for the trial division prime test
package tdpt_pkg;

	localparam int VALUE_BITS_DEF = 27;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_TEST,
		ST_REPORT
	} state_t;

endpackage

// ===== src/trial_division_prime_test.sv =====
// top level: trial division primality test with a bit-serial restoring divider
//
// Input channel: in_valid / in_ready carry one candidate. An accepted request
// is answered by one result on out_valid / out_ready with is_prime set when the
// candidate is prime (0 and 1 are not prime, 2 is, other even values are not).
// Odd candidates from 3 up are divided by 3, 5, 7, ... One division runs
// through a restoring divider that takes one quotient bit per cycle and is
// followed by a test step. The same division gives quotient and remainder;
// the search ends when the divisor exceeds the quotient (prime) or a
// remainder is zero (composite).
// Values below 3 and even values go from the check state straight to the
// report state. For odd values the number of divisors tried is at most
// about 2^(VALUE_BITS/2) / 2.
// One candidate is in work at a time; in_ready is high while no candidate is
// in work, even while a result waits in the output register. If the receiver
// stalls, the finished result waits in the report state until the output
// register is free. Reset (arst_n low) empties the block: no result pending.
module trial_division_prime_test
	import tdpt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [VALUE_BITS-1:0] candidate,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_prime
);

	localparam int DIV_BITS = VALUE_BITS / 2 + 2;
	localparam int CNT_W    = $clog2(VALUE_BITS);

	state_t state_q, state_d;

	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] quot_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [DIV_BITS-1:0]   div_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  res_q;
	logic                  out_valid_q;
	logic                  out_q;

	logic [DIV_BITS:0]     trial;
	logic [DIV_BITS:0]     diff;
	logic                  qbit;
	logic                  last_bit;
	logic                  out_free;
	logic                  div_above;

	// one restoring step: bring down the next dividend bit
	assign trial     = {rem_q, quot_q[VALUE_BITS-1]};
	assign diff      = trial - {1'b0, div_q};
	assign qbit      = !diff[DIV_BITS];
	assign last_bit  = (cnt_q == CNT_W'(VALUE_BITS - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign div_above = (VALUE_BITS'(div_q) > quot_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (cand_q < VALUE_BITS'(3) || !cand_q[0]) begin
					state_d = ST_REPORT;
				end else begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (last_bit) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (div_above || rem_q == '0) begin
					state_d = ST_REPORT;
				end else begin
					state_d = ST_DIVIDE;
				end
			end
			ST_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cand_q <= candidate;
				end
			end
			ST_CHECK: begin
				res_q  <= (cand_q == VALUE_BITS'(2));
				div_q  <= DIV_BITS'(3);
				quot_q <= cand_q;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			ST_DIVIDE: begin
				rem_q  <= qbit ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
				quot_q <= {quot_q[VALUE_BITS-2:0], qbit};
				cnt_q  <= cnt_q + CNT_W'(1);
			end
			ST_TEST: begin
				res_q  <= div_above;
				div_q  <= div_q + DIV_BITS'(2);
				quot_q <= cand_q;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			default: begin
			end
		endcase
	end

	// output register, loaded from the report state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_REPORT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_REPORT && out_free) begin
			out_q <= res_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = out_q;

	// partial remainder always stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE || state_q == ST_TEST) |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

	// trial divisors are odd and at least three
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (div_q[0] && div_q >= DIV_BITS'(3)))
		else $error("trial divisor not odd or below three");

	// an accepted request moves straight to the range check
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CHECK))
		else $error("accepted request not checked");

	// the test state is reached only from the last step of a divide pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEST) |-> ($past(state_q) == ST_DIVIDE && $past(last_bit)))
		else $error("test reached without a full divide pass");

endmodule
